FILE: hw/rtl/hec_pkg.sv
package hec_pkg;

    // Fixed field widths
    localparam int C_WORD_W  = 31;
    localparam int C_CHK_W   = 5;
    localparam int C_CNT_W   = 3;
    localparam int C_LEN_W   = 5;

    // Longest message supported, and the longest whose codeword fits 31 bits
    localparam int C_MAX_DATA_BITS = 26;
    localparam int C_FIT_DATA_BITS = 26;
    localparam int C_CAP_DATA_BITS = (C_MAX_DATA_BITS < C_FIT_DATA_BITS) ?
                                     C_MAX_DATA_BITS : C_FIT_DATA_BITS;
    localparam logic [C_LEN_W-1:0] C_DATA_BITS_RST = 5'd8;

    // Configuration register indexes
    localparam logic C_REG_DATA_BITS = 1'b0;

    // Command codes
    localparam logic C_CMD_ENCODE = 1'b0;
    localparam logic C_CMD_CHECK  = 1'b1;

    // Non-power-of-two codeword positions, in the order data bits fill them
    localparam logic [4:0] C_DATA_POS [C_FIT_DATA_BITS] = '{
        5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13,
        5'd14, 5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
        5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
    };

    typedef struct packed {
        logic                cmd;
        logic [C_WORD_W-1:0] word;
    } t_hec_in;

    typedef struct packed {
        logic [C_WORD_W-1:0] codeword;
        logic [C_CHK_W-1:0]  check_bits;
        logic [C_CNT_W-1:0]  check_count;
        logic [C_LEN_W-1:0]  error_position;
        logic                error_found;
    } t_hec_out;

    // Check-bit count: smallest k with 2^k >= d + k + 1
    function automatic logic [C_CNT_W-1:0] check_count_of(input logic [C_LEN_W-1:0] d);
        logic [C_CNT_W-1:0] k;
        if (d <= 5'd1) begin
            k = 3'd2;
        end else if (d <= 5'd4) begin
            k = 3'd3;
        end else if (d <= 5'd11) begin
            k = 3'd4;
        end else begin
            k = 3'd5;
        end
        return k;
    endfunction

endpackage

FILE: hw/rtl/hec_cfg.sv
module hec_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [hec_pkg::C_LEN_W-1:0] o_data_bits
);
    import hec_pkg::*;

    logic [C_LEN_W-1:0] r_data_bits;
    logic [C_LEN_W-1:0] n_data_bits;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == C_REG_DATA_BITS);

    always_comb begin
        n_data_bits = r_data_bits;
        if (wr_en) begin
            n_data_bits = pwdata[C_LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_bits <= C_DATA_BITS_RST;
        end else begin
            r_data_bits <= n_data_bits;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == C_REG_DATA_BITS) begin
            prdata = {{(32-C_LEN_W){1'b0}}, r_data_bits};
        end
    end

    assign o_data_bits = r_data_bits;

endmodule

FILE: hw/rtl/hec_core.sv
module hec_core (
    input  logic [hec_pkg::C_LEN_W-1:0] i_data_bits,
    input  hec_pkg::t_hec_in            i_req,
    output hec_pkg::t_hec_out           o_rsp
);
    import hec_pkg::*;

    logic [C_LEN_W-1:0]  d;
    logic [C_CNT_W-1:0]  k;
    logic [C_LEN_W-1:0]  total;
    logic [C_LEN_W-1:0]  sh_tot;
    logic [C_FIT_DATA_BITS-1:0] data_al;
    // Position-aligned words: bit (31 - p) holds codeword position p
    logic [C_WORD_W-1:0] a_chk;
    logic [C_WORD_W-1:0] a_enc;
    logic [C_WORD_W-1:0] a_sel;
    logic [C_WORD_W-1:0] a_fin;
    logic [C_CHK_W-1:0]  par;
    logic [C_CHK_W-1:0]  syn;
    logic [C_CHK_W-1:0]  cb;
    logic [C_CNT_W-1:0]  idx;

    // Clamp the data length to the supported range
    always_comb begin
        d = i_data_bits;
        if (d == '0) begin
            d = 5'd1;
        end
        if (d > C_LEN_W'(C_CAP_DATA_BITS)) begin
            d = C_LEN_W'(C_CAP_DATA_BITS);
        end
    end

    assign k      = check_count_of(d);
    assign total  = d + {2'b00, k};
    assign sh_tot = 5'd31 - total;

    assign a_chk   = i_req.word << sh_tot;
    assign data_al = i_req.word[C_FIT_DATA_BITS-1:0] << (5'd26 - d);

    // Spread data bits into the non-power-of-two positions
    always_comb begin
        a_enc = '0;
        for (int n = 0; n < C_FIT_DATA_BITS; n++) begin
            a_enc[5'd31 - C_DATA_POS[n]] = data_al[C_FIT_DATA_BITS-1-n];
        end
    end

    assign a_sel = (i_req.cmd == C_CMD_CHECK) ? a_chk : a_enc;

    // Even parity per check bit, over the positions it covers except its own
    always_comb begin
        par = '0;
        for (int i = 0; i < C_CHK_W; i++) begin
            for (int p = 1; p <= C_WORD_W; p++) begin
                if (((p >> i) & 1) == 1 && p != (1 << i)) begin
                    par[i] = par[i] ^ a_sel[C_WORD_W - p];
                end
            end
        end
    end

    // Syndrome and codeword with check bits inserted
    always_comb begin
        a_fin = a_enc;
        for (int i = 0; i < C_CHK_W; i++) begin
            syn[i] = par[i] ^ a_sel[C_WORD_W - (1 << i)];
            a_fin[C_WORD_W - (1 << i)] = par[i];
        end
    end

    // Reorder: the parity for position 1 goes in bit k-1
    always_comb begin
        cb  = '0;
        idx = '0;
        for (int j = 0; j < C_CHK_W; j++) begin
            idx = k - 3'd1 - 3'(j);
            if (3'(j) < k) begin
                cb[j] = par[idx];
            end
        end
    end

    always_comb begin
        o_rsp.check_bits  = cb;
        o_rsp.check_count = k;
        if (i_req.cmd == C_CMD_CHECK) begin
            o_rsp.codeword       = i_req.word;
            o_rsp.error_position = syn;
            o_rsp.error_found    = |syn;
        end else begin
            o_rsp.codeword       = a_fin >> sh_tot;
            o_rsp.error_position = '0;
            o_rsp.error_found    = 1'b0;
        end
    end

endmodule

FILE: hw/rtl/hamming_encode_and_check.sv
// Hamming single-error-correcting coder and checker.
// Requests arrive on the input channel (i_in_valid / o_in_ready / i_in_data):
// cmd selects encode (data word in, codeword out) or check (received codeword
// in, syndrome out). Each request gives exactly one response on the output
// channel (o_out_valid / i_out_ready / o_out_data).
// The data length is set through the APB port, register 0 (data_bits), and
// must only be changed while no request is in flight.
// Path: a request accepted on the input channel is registered, coded by a
// single combinational pass, and lands in the output register when that
// register is free or its response is being taken.
// Throughput: one request per cycle, limited only by the one-deep input
// register and the output register; both advance together whenever the
// output is free or being taken.
// When the receiver stalls, the output register holds its response and the
// input register holds one more request; o_in_ready drops once both are full.
// Reset (i_rst_n low, synchronous) empties both registers and sets data_bits
// to 8.
module hamming_encode_and_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hec_pkg::t_hec_in     i_in_data,
    // Response channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hec_pkg::t_hec_out    o_out_data,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import hec_pkg::*;

    logic [C_LEN_W-1:0] data_bits;

    // Input register
    logic     r_s1_valid;
    logic     n_s1_valid;
    t_hec_in  r_s1_data;
    // Output register
    logic     r_out_valid;
    logic     n_out_valid;
    t_hec_out r_out_data;
    t_hec_out core_rsp;

    logic     out_free;
    logic     in_take;

    hec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_data_bits (data_bits)
    );

    hec_core u_core (
        .i_data_bits (data_bits),
        .i_req       (r_s1_data),
        .o_rsp       (core_rsp)
    );

    // The output register can load when empty or when its response is taken
    assign out_free   = !r_out_valid || i_out_ready;
    // The input register can load when empty or when it advances
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (out_free) begin
            // advance the coded request, or drop the taken response
            n_out_valid = r_s1_valid;
            n_s1_valid  = in_take;
        end else if (in_take) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_in_data;
        end
        if (out_free && r_s1_valid) begin
            r_out_data <= core_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
